/* design/jva_pkg.sv */
// Shared types, codes and reset values for the joystick / voice arbiter.
package jva_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int TIME_BITS       = 32;
    localparam int MS_BITS         = 16;
    localparam int CFG_DATA_BITS   = 16;
    localparam int CFG_INDEX_BITS  = 3;
    localparam int CMD_BITS        = 3;
    localparam int MODE_BITS       = 2;

    // Reset values of the configuration registers
    localparam int NEUTRAL_RESET   = 2045;
    localparam int DEAD_ZONE_RESET = 300;
    localparam int FULL_RESET      = 4090;
    localparam int HOLD_MS_RESET   = 3000;
    localparam int DEBOUNCE_RESET  = 300;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    localparam cfg_index_t CFG_NEUTRAL   = 3'd0;
    localparam cfg_index_t CFG_DEAD_ZONE = 3'd1;
    localparam cfg_index_t CFG_FULL      = 3'd2;
    localparam cfg_index_t CFG_HOLD_MS   = 3'd3;
    localparam cfg_index_t CFG_DEBOUNCE  = 3'd4;

    typedef logic [CMD_BITS-1:0] cmd_t;
    localparam cmd_t CMD_FWD   = 3'd1;
    localparam cmd_t CMD_BACK  = 3'd2;
    localparam cmd_t CMD_STOP  = 3'd3;
    localparam cmd_t CMD_LEFT  = 3'd4;
    localparam cmd_t CMD_RIGHT = 3'd5;

    typedef logic [MODE_BITS-1:0] mode_code_t;
    localparam mode_code_t MODE_CODE_IDLE  = 2'd0;
    localparam mode_code_t MODE_CODE_JOY   = 2'd1;
    localparam mode_code_t MODE_CODE_VOICE = 2'd2;
    localparam mode_code_t MODE_CODE_HOLD  = 2'd3;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'b001,
        MODE_JOY   = 3'b010,
        MODE_VOICE = 3'b100
    } mode_t;

    typedef struct packed {
        mode_t                 mode;
        cmd_t                  cmd;
        logic                  stop_active;
        logic [TIME_BITS-1:0]  deadline;
        logic [TIME_BITS-1:0]  last_press;
    } arb_state_t;

    function automatic mode_code_t mode_encode(input mode_t m);
        mode_code_t code;
        case (m)
            MODE_IDLE: code = MODE_CODE_IDLE;
            MODE_JOY:  code = MODE_CODE_JOY;
            default:   code = MODE_CODE_VOICE;
        endcase
        return code;
    endfunction

endpackage

/* design/joystick_voice_arbiter_estop.sv */
// Top level of the joystick / voice arbiter with emergency stop.
// Each request is registered in the input register on acceptance, then handled by
// jva_step, and a joystick sample leaves its result in an output register; one
// request can be accepted every cycle while the input does not stall. An E-stop press
// (req_type 1) updates the stop state and returns no result. Input stalls only
// when the input register holds a sample while the output register is full and
// not being taken. Configuration is written through wr_en / wr_index / wr_data
// and must only change while no request is in flight.
module joystick_voice_arbiter_estop
    import jva_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  logic [CFG_INDEX_BITS-1:0] wr_index,
    input  logic [CFG_DATA_BITS-1:0]  wr_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      req_type,
    input  logic [TIME_BITS-1:0]      now_ms,
    input  logic [SAMPLE_BITS-1:0]    axis_x,
    input  logic [SAMPLE_BITS-1:0]    axis_y,
    input  logic [SAMPLE_BITS-1:0]    axis_z,
    input  logic                      voice_valid,
    input  logic [7:0]                voice_cmd,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [SAMPLE_BITS-1:0]    out_x,
    output logic [SAMPLE_BITS-1:0]    out_y,
    output logic [SAMPLE_BITS-1:0]    out_z,
    output logic [MODE_BITS-1:0]      mode_now,
    output logic                      voice_taken,
    output logic [CMD_BITS-1:0]       command_now
);

    logic [SAMPLE_BITS-1:0] neutral_reg;
    logic [SAMPLE_BITS-1:0] dead_zone_reg;
    logic [SAMPLE_BITS-1:0] full_scale_reg;
    logic [MS_BITS-1:0]     hold_ms_reg;
    logic [MS_BITS-1:0]     debounce_reg;

    logic                   inp_valid_reg;
    logic                   inp_press_reg;
    logic [TIME_BITS-1:0]   inp_now_reg;
    logic [SAMPLE_BITS-1:0] inp_x_reg;
    logic [SAMPLE_BITS-1:0] inp_y_reg;
    logic [SAMPLE_BITS-1:0] inp_z_reg;
    logic                   inp_vvalid_reg;
    logic [7:0]             inp_vcmd_reg;

    arb_state_t             st_reg;
    arb_state_t             st_next;

    logic                   res_valid_reg;
    logic [SAMPLE_BITS-1:0] res_x_reg;
    logic [SAMPLE_BITS-1:0] res_y_reg;
    logic [SAMPLE_BITS-1:0] res_z_reg;
    mode_code_t             res_mode_reg;
    logic                   res_taken_reg;
    cmd_t                   res_cmd_reg;

    logic [SAMPLE_BITS-1:0] tx;
    logic [SAMPLE_BITS-1:0] ty;
    logic [SAMPLE_BITS-1:0] tz;
    mode_code_t             mode_code;
    logic                   taken;
    logic                   stage_go;
    logic                   in_fire;

    // A press needs no result slot; a sample needs a free or draining one
    assign stage_go = inp_valid_reg && (inp_press_reg || !res_valid_reg || out_ready);
    assign in_ready = !inp_valid_reg || stage_go;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neutral_reg    <= SAMPLE_BITS'(NEUTRAL_RESET);
            dead_zone_reg  <= SAMPLE_BITS'(DEAD_ZONE_RESET);
            full_scale_reg <= SAMPLE_BITS'(FULL_RESET);
            hold_ms_reg    <= MS_BITS'(HOLD_MS_RESET);
            debounce_reg   <= MS_BITS'(DEBOUNCE_RESET);
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_NEUTRAL:   neutral_reg    <= wr_data[SAMPLE_BITS-1:0];
                CFG_DEAD_ZONE: dead_zone_reg  <= wr_data[SAMPLE_BITS-1:0];
                CFG_FULL:      full_scale_reg <= wr_data[SAMPLE_BITS-1:0];
                CFG_HOLD_MS:   hold_ms_reg    <= wr_data[MS_BITS-1:0];
                CFG_DEBOUNCE:  debounce_reg   <= wr_data[MS_BITS-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inp_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            inp_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            inp_press_reg  <= req_type;
            inp_now_reg    <= now_ms;
            inp_x_reg      <= axis_x;
            inp_y_reg      <= axis_y;
            inp_z_reg      <= axis_z;
            inp_vvalid_reg <= voice_valid;
            inp_vcmd_reg   <= voice_cmd;
        end
    end

    jva_step #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_step (
        .st            (st_reg),
        .press         (inp_press_reg),
        .now_ms        (inp_now_reg),
        .axis_x        (inp_x_reg),
        .axis_y        (inp_y_reg),
        .axis_z        (inp_z_reg),
        .voice_valid   (inp_vvalid_reg),
        .voice_cmd     (inp_vcmd_reg),
        .neutral_level (neutral_reg),
        .dead_zone     (dead_zone_reg),
        .full_scale    (full_scale_reg),
        .stop_hold_ms  (hold_ms_reg),
        .debounce_ms   (debounce_reg),
        .st_next       (st_next),
        .tx            (tx),
        .ty            (ty),
        .tz            (tz),
        .mode_code     (mode_code),
        .taken         (taken)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.mode        <= MODE_IDLE;
            st_reg.cmd         <= CMD_STOP;
            st_reg.stop_active <= 1'b0;
            st_reg.deadline    <= '0;
            st_reg.last_press  <= '0;
        end
        else if (stage_go)
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (stage_go && !inp_press_reg)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_go && !inp_press_reg)
        begin
            res_x_reg     <= tx;
            res_y_reg     <= ty;
            res_z_reg     <= tz;
            res_mode_reg  <= mode_code;
            res_taken_reg <= taken;
            res_cmd_reg   <= st_next.cmd;
        end
    end

    assign out_valid   = res_valid_reg;
    assign out_x       = res_x_reg;
    assign out_y       = res_y_reg;
    assign out_z       = res_z_reg;
    assign mode_now    = res_mode_reg;
    assign voice_taken = res_taken_reg;
    assign command_now = res_cmd_reg;

endmodule

/* design/jva_step.sv */
// Next-state and output logic for one request of the arbiter.
module jva_step
    import jva_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  arb_state_t             st,
    input  logic                   press,
    input  logic [TIME_BITS-1:0]   now_ms,
    input  logic [SAMPLE_BITS-1:0] axis_x,
    input  logic [SAMPLE_BITS-1:0] axis_y,
    input  logic [SAMPLE_BITS-1:0] axis_z,
    input  logic                   voice_valid,
    input  logic [7:0]             voice_cmd,
    input  logic [SAMPLE_BITS-1:0] neutral_level,
    input  logic [SAMPLE_BITS-1:0] dead_zone,
    input  logic [SAMPLE_BITS-1:0] full_scale,
    input  logic [MS_BITS-1:0]     stop_hold_ms,
    input  logic [MS_BITS-1:0]     debounce_ms,
    output arb_state_t             st_next,
    output logic [SAMPLE_BITS-1:0] tx,
    output logic [SAMPLE_BITS-1:0] ty,
    output logic [SAMPLE_BITS-1:0] tz,
    output mode_code_t             mode_code,
    output logic                   taken
);

    function automatic logic axis_active(input logic [SAMPLE_BITS-1:0] v,
                                         input logic [SAMPLE_BITS-1:0] ctr,
                                         input logic [SAMPLE_BITS-1:0] dz);
        logic [SAMPLE_BITS-1:0] d;
        d = (v >= ctr) ? (v - ctr) : (ctr - v);
        return d > dz;
    endfunction

    logic [TIME_BITS-1:0] since_press;
    logic [TIME_BITS-1:0] left;
    logic                 holding;
    logic                 act;

    assign since_press = now_ms - st.last_press;
    assign left        = st.deadline - now_ms;
    // Deadline still ahead: nonzero distance with the sign bit clear
    assign holding     = st.stop_active && (left != '0) && !left[TIME_BITS-1];
    assign act         = axis_active(axis_x, neutral_level, dead_zone)
                       || axis_active(axis_y, neutral_level, dead_zone)
                       || axis_active(axis_z, neutral_level, dead_zone);

    always_comb
    begin
        st_next   = st;
        tx        = neutral_level;
        ty        = neutral_level;
        tz        = neutral_level;
        taken     = 1'b0;
        mode_code = MODE_CODE_HOLD;
        if (press)
        begin
            if (since_press >= {{(TIME_BITS-MS_BITS){1'b0}}, debounce_ms})
            begin
                st_next.last_press  = now_ms;
                st_next.deadline    = now_ms + {{(TIME_BITS-MS_BITS){1'b0}}, stop_hold_ms};
                st_next.stop_active = 1'b1;
            end
        end
        else if (holding)
        begin
            st_next.mode = MODE_IDLE;
            st_next.cmd  = CMD_STOP;
        end
        else
        begin
            st_next.stop_active = 1'b0;
            // Consume a waiting voice frame only with the stick centered
            if (!act && voice_valid)
            begin
                taken = 1'b1;
                if (voice_cmd inside {[CMD_FWD:CMD_RIGHT]})
                begin
                    st_next.cmd  = voice_cmd[CMD_BITS-1:0];
                    st_next.mode = MODE_VOICE;
                end
            end
            case (st_next.mode)
                MODE_IDLE:
                begin
                    if (act)
                    begin
                        st_next.mode = MODE_JOY;
                    end
                end
                MODE_JOY:
                begin
                    if (!act)
                    begin
                        st_next.mode = MODE_IDLE;
                    end
                    else
                    begin
                        tx = axis_x;
                        ty = axis_y;
                        tz = axis_z;
                    end
                end
                default:
                begin
                    if (act)
                    begin
                        st_next.mode = MODE_JOY;
                        tx = axis_x;
                        ty = axis_y;
                        tz = axis_z;
                    end
                    else
                    begin
                        case (st_next.cmd)
                            CMD_FWD:   ty = full_scale;
                            CMD_BACK:  ty = '0;
                            CMD_LEFT:  tx = '0;
                            CMD_RIGHT: tx = full_scale;
                            default:   ;
                        endcase
                    end
                end
            endcase
            mode_code = mode_encode(st_next.mode);
        end
    end

endmodule

/* design/jva_checker.sv */
// Port-level checks for the arbiter, bound to the top level.
module jva_checker
    import jva_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [SAMPLE_BITS-1:0] out_x,
    input logic [MODE_BITS-1:0]   mode_now,
    input logic                   voice_taken,
    input logic [CMD_BITS-1:0]    command_now
);

    // Hold a stalled result unchanged
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_x)
            && $stable(mode_now) && $stable(command_now) && $stable(voice_taken))
        else $error("stalled result changed");

    // A stop hold forces the STOP command and blocks voice frames
    a_hold_stop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mode_now == MODE_CODE_HOLD |-> !voice_taken && command_now == CMD_STOP)
        else $error("hold result carries voice activity");

    // Consuming a voice frame implies a centered stick, never joystick mode
    a_taken_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && voice_taken |-> mode_now != MODE_CODE_JOY && mode_now != MODE_CODE_HOLD)
        else $error("voice frame taken with stick active");

    a_cmd_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> command_now >= CMD_FWD && command_now <= CMD_RIGHT)
        else $error("command out of range");

    // Backpressure reaches the input only through a blocked result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a blocked result");

endmodule

bind joystick_voice_arbiter_estop jva_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_jva_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_x       (out_x),
    .mode_now    (mode_now),
    .voice_taken (voice_taken),
    .command_now (command_now)
);
